@@ rtl/mm_pkg.sv @@
// Shared types, constants and helpers for the matrix multiply block.
package mm_pkg;

    // Dimension registers and configuration port
    localparam int DIM_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd2;

    // Stream payload widths
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_VALUE_W = 32;
    localparam int OUT_IDX_W   = 3;
    localparam int OUT_TDATA_W = 40;

    // Q16.16 result limits and rounding position
    localparam logic [OUT_VALUE_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [OUT_VALUE_W-1:0] Q_MIN = 32'h8000_0000;
    localparam int FRAC_W = 16;

    // Job handed from the loader to the compute engine
    typedef struct packed {
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] inner;
        logic [DIM_W-1:0] cols;
    } job_t;

    // Stored element width: above 32 bits the input is a zero-extended word,
    // so one extra sign bit is enough to hold it.
    function automatic int elem_width(input int dw);
        return (dw > 32) ? 33 : dw;
    endfunction

endpackage

@@ rtl/mm_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mm_front.sv @@
// Loader: configuration registers, element classification and store writes.
module mm_front import mm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]                  cfg_index,
    input  logic [DIM_W-1:0]                      cfg_data,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [IN_TDATA_W-1:0]                 s_tdata,
    input  logic                                  back_busy,
    input  logic                                  q_empty,
    output logic                                  left_we,
    output logic                                  right_we,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]    wr_addr,
    output logic [elem_width(DATA_WIDTH)-1:0]     wr_data,
    output logic                                  job_push,
    output job_t                                  job
);

    localparam int ELEM_W = elem_width(DATA_WIDTH);
    localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
    localparam int LP_W   = $clog2(2*MAX_DIM*MAX_DIM + 1);

    logic [DIM_W-1:0]   row_count_reg, inner_count_reg, column_count_reg;
    logic [LP_W-1:0]    lp_reg, lp_next;
    logic [DIM_W-1:0]   rows, inner, cols;
    logic [2*DIM_W-1:0] left_prod, right_prod;
    logic [LP_W-1:0]    left_n, total, lp_inc;
    logic               accept, cfg_hit, burst_done;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        priority if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

    // Effective dimensions and matrix sizes
    assign rows  = clamp_dim(row_count_reg);
    assign inner = clamp_dim(inner_count_reg);
    assign cols  = clamp_dim(column_count_reg);

    assign left_prod  = {{DIM_W{1'b0}}, rows} * {{DIM_W{1'b0}}, inner};
    assign right_prod = {{DIM_W{1'b0}}, inner} * {{DIM_W{1'b0}}, cols};
    assign left_n     = LP_W'(left_prod);
    assign total      = LP_W'(left_prod + right_prod);

    // Handshakes: take elements only when the engine no longer reads the stores
    assign cfg_ready = 1'b1;
    assign s_tready  = !back_busy && q_empty;
    assign accept    = s_tvalid && s_tready;
    assign cfg_hit   = cfg_valid && (cfg_index == REG_ROW_COUNT ||
                                     cfg_index == REG_INNER_COUNT ||
                                     cfg_index == REG_COLUMN_COUNT);

    // Classify the element as part of A or B
    assign lp_inc     = lp_reg + LP_W'(1);
    assign burst_done = accept && (lp_inc == total);
    assign left_we    = accept && (lp_reg < left_n);
    assign right_we   = accept && !(lp_reg < left_n);
    assign wr_addr    = (lp_reg < left_n) ? ADDR_W'(lp_reg) : ADDR_W'(lp_reg - left_n);
    assign wr_data    = ELEM_W'(s_tdata);

    assign job_push   = burst_done;
    assign job.rows   = rows;
    assign job.inner  = inner;
    assign job.cols   = cols;

    always_comb
    begin
        lp_next = lp_reg;
        priority if (cfg_hit)
            lp_next = '0;
        else if (burst_done)
            lp_next = '0;
        else if (accept)
            lp_next = lp_inc;
    end

    // Configuration registers and load position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= DIM_W'(1);
            inner_count_reg  <= DIM_W'(1);
            column_count_reg <= DIM_W'(1);
            lp_reg           <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_ROW_COUNT:    row_count_reg    <= cfg_data;
                    REG_INNER_COUNT:  inner_count_reg  <= cfg_data;
                    REG_COLUMN_COUNT: column_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            lp_reg <= lp_next;
        end
    end

endmodule

@@ rtl/mm_job_queue.sv @@
// Two-entry job queue between the loader and the compute engine.
module mm_job_queue import mm_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t job_in,
    input  logic pop,
    output job_t job_out,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign empty   = (count_reg == 2'd0);
    assign job_out = mem_reg[rd_ptr_reg];

    // Entries hold payload only
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_in;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ rtl/mm_back.sv @@
// Compute engine: one multiply-accumulate unit walking C in row-major order.
module mm_back import mm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 job_valid,
    input  job_t                                 job_in,
    output logic                                 job_pop,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   left_raddr,
    output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   right_raddr,
    input  logic [elem_width(DATA_WIDTH)-1:0]    left_rdata,
    input  logic [elem_width(DATA_WIDTH)-1:0]    right_rdata,
    output logic                                 busy,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [OUT_VALUE_W-1:0]               product_value,
    output logic [OUT_IDX_W-1:0]                 product_row,
    output logic [OUT_IDX_W-1:0]                 product_column,
    output logic                                 last_element
);

    localparam int ELEM_W  = elem_width(DATA_WIDTH);
    localparam int ADDR_W  = $clog2(MAX_DIM*MAX_DIM);
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int PROD_W  = 2*ELEM_W;
    localparam int ACC_MIN = PROD_W + $clog2(MAX_DIM) + 1;
    localparam int ACC_W   = (ACC_MIN > 49) ? ACC_MIN : 49;
    localparam int SH_W    = ACC_W - FRAC_W;
    localparam logic signed [ACC_W-1:0] HALF_LSB = ACC_W'(17'sd32768);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]              state_reg, state_next;
    job_t                    job_reg, job_next;
    logic [IDX_W-1:0]        i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [ADDR_W-1:0]       lbase_reg, lbase_next, rptr_reg, rptr_next;
    logic                    rd_v_reg, rd_first_reg, rd_last_reg;
    logic                    mul_v_reg, mul_first_reg, mul_last_reg;
    logic signed [PROD_W-1:0] mul_reg;
    logic signed [ACC_W-1:0] acc_reg, prod_ext, rnd;
    logic signed [SH_W-1:0]  sh;
    logic [SH_W-32:0]        sh_top;
    logic [OUT_VALUE_W-1:0]  sat_value;
    logic                    sum_v_reg;
    logic                    out_valid_reg, last_reg;
    logic [OUT_VALUE_W-1:0]  value_reg;
    logic [OUT_IDX_W-1:0]    row_reg, col_reg;
    logic                    issue, k_last, j_last, i_last, out_free, fin;

    // Loop position
    assign issue  = (state_reg == ST_RUN);
    assign k_last = (DIM_W'(k_reg) == job_reg.inner - DIM_W'(1));
    assign j_last = (DIM_W'(j_reg) == job_reg.cols - DIM_W'(1));
    assign i_last = (DIM_W'(i_reg) == job_reg.rows - DIM_W'(1));

    assign left_raddr  = lbase_reg + ADDR_W'(k_reg);
    assign right_raddr = rptr_reg;

    assign out_free = !out_valid_reg || out_ready;
    assign fin      = sum_v_reg && out_free;
    assign busy     = (state_reg != ST_IDLE);

    // Sequencer over (i, j, k)
    always_comb
    begin
        state_next = state_reg;
        job_next   = job_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        lbase_next = lbase_reg;
        rptr_next  = rptr_reg;
        job_pop    = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    job_pop    = 1'b1;
                    job_next   = job_in;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                    lbase_next = '0;
                    rptr_next  = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_WAIT;
                end
                else
                begin
                    k_next    = k_reg + IDX_W'(1);
                    rptr_next = rptr_reg + ADDR_W'(job_reg.cols);
                end
            end
            ST_WAIT:
            begin
                if (fin)
                begin
                    if (i_last && j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_RUN;
                        if (j_last)
                        begin
                            j_next     = '0;
                            i_next     = i_reg + IDX_W'(1);
                            lbase_next = lbase_reg + ADDR_W'(job_reg.inner);
                            rptr_next  = '0;
                        end
                        else
                        begin
                            j_next    = j_reg + IDX_W'(1);
                            rptr_next = ADDR_W'(j_reg) + ADDR_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Rounding to Q16.16 and saturation
    assign prod_ext  = ACC_W'(mul_reg);
    assign rnd       = acc_reg + HALF_LSB;
    assign sh        = rnd[ACC_W-1:FRAC_W];
    assign sh_top    = sh[SH_W-1:31];

    always_comb
    begin
        priority if (sh_top == '0 || sh_top == '1)
            sat_value = sh[31:0];
        else if (sh[SH_W-1])
            sat_value = Q_MIN;
        else
            sat_value = Q_MAX;
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (rd_v_reg)
        begin
            mul_reg <= $signed(left_rdata) * $signed(right_rdata);
        end
        if (mul_v_reg)
        begin
            acc_reg <= mul_first_reg ? prod_ext : acc_reg + prod_ext;
        end
        if (fin)
        begin
            value_reg <= sat_value;
            row_reg   <= OUT_IDX_W'(i_reg);
            col_reg   <= OUT_IDX_W'(j_reg);
            last_reg  <= i_last && j_last;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            job_reg       <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            lbase_reg     <= '0;
            rptr_reg      <= '0;
            rd_v_reg      <= 1'b0;
            rd_first_reg  <= 1'b0;
            rd_last_reg   <= 1'b0;
            mul_v_reg     <= 1'b0;
            mul_first_reg <= 1'b0;
            mul_last_reg  <= 1'b0;
            sum_v_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            job_reg       <= job_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            lbase_reg     <= lbase_next;
            rptr_reg      <= rptr_next;
            rd_v_reg      <= issue;
            rd_first_reg  <= (k_reg == '0);
            rd_last_reg   <= k_last;
            mul_v_reg     <= rd_v_reg;
            mul_first_reg <= rd_first_reg;
            mul_last_reg  <= rd_last_reg;
            if (mul_v_reg && mul_last_reg)
                sum_v_reg <= 1'b1;
            else if (fin)
                sum_v_reg <= 1'b0;
            if (fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid      = out_valid_reg;
    assign product_value  = value_reg;
    assign product_row    = row_reg;
    assign product_column = col_reg;
    assign last_element   = last_reg;

endmodule

@@ rtl/matrix_multiply.sv @@
// After the last B element is accepted, its job passes the job queue, and the read, multiply,
// accumulate and output registers then carry the first C element out. Loading takes one element
// per cycle while the engine is idle and no job waits. Each C element is computed by the single
// multiply-accumulate unit reading one A and one B word per cycle; the next starts once the
// previous sum is passed to the output. Input is held off during computation; reset clears
// control state, dimensions to 1, and leaves the element stores undefined (no clearing pass).
module matrix_multiply import mm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // Configuration write channel
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [DIM_W-1:0]       cfg_data,
    // Element input
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] element_value
    // Product output
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] product_value, [34:32] product_row,
                                              // [37:35] product_column, [39:38] zero
    output logic                   m_tlast    // last_element
);

    localparam int ELEM_W = elem_width(DATA_WIDTH);
    localparam int DEPTH  = MAX_DIM*MAX_DIM;
    localparam int ADDR_W = $clog2(DEPTH);

    logic              left_we, right_we, job_push, job_pop, q_empty, back_busy;
    logic [ADDR_W-1:0] wr_addr, left_raddr, right_raddr;
    logic [ELEM_W-1:0] wr_data, left_rdata, right_rdata;
    job_t              job_front, job_back;
    logic [OUT_VALUE_W-1:0] product_value;
    logic [OUT_IDX_W-1:0]   product_row, product_column;

    // Loader
    mm_front #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .back_busy (back_busy),
        .q_empty   (q_empty),
        .left_we   (left_we),
        .right_we  (right_we),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .job_push  (job_push),
        .job       (job_front)
    );

    // Element stores
    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_left_store (
        .clk   (clk),
        .we    (left_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (left_raddr),
        .rdata (left_rdata)
    );

    mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_right_store (
        .clk   (clk),
        .we    (right_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (right_raddr),
        .rdata (right_rdata)
    );

    // Job queue
    mm_job_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (job_push),
        .job_in  (job_front),
        .pop     (job_pop),
        .job_out (job_back),
        .empty   (q_empty)
    );

    // Compute engine
    mm_back #(
        .MAX_DIM    (MAX_DIM),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (!q_empty),
        .job_in         (job_back),
        .job_pop        (job_pop),
        .left_raddr     (left_raddr),
        .right_raddr    (right_raddr),
        .left_rdata     (left_rdata),
        .right_rdata    (right_rdata),
        .busy           (back_busy),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .product_value  (product_value),
        .product_row    (product_row),
        .product_column (product_column),
        .last_element   (m_tlast)
    );

    assign m_tdata = {2'b00, product_column, product_row, product_value};

    // A job is posted only into an empty queue, so it never overflows
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> q_empty)
        else $error("job posted while queue holds a job");

    // The engine only takes a job that is present
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> !q_empty)
        else $error("job taken from empty queue");

    // Stores are never written while the engine may still read them
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_we || right_we) |-> (!back_busy && !job_pop))
        else $error("store written during computation");

endmodule
